// ===== hdl/size_class_slab_allocator_assert.svh =====
// Assertion macros shared by the slab allocator RTL.
`ifndef SIZE_CLASS_SLAB_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_SLAB_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define SCSA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define SCSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/scsa_pkg.sv =====
// Types, constants and the class search shared by the slab allocator.
package scsa_pkg;

  localparam int NumClasses    = 4;
  localparam int SlotsPerClass = 1024;
  localparam int CfgClasses    = 4;

  localparam int SizeW    = 16;
  localparam int SlotW    = 10;
  localparam int ClassW   = 2;
  localparam int CountW   = 11;
  localparam int LinkW    = SlotW + 1;
  localparam int AddrW    = ClassW + SlotW;
  localparam int RamDepth = NumClasses * SlotsPerClass;
  localparam int InUseW   = 3;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int ProdW    = 2 * CountW;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_RESIZE = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_FREED     = 3'd1,
    ST_OVERSIZE  = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_NOOP      = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CLASS_SIZE_0    = 3'd0,
    CFG_CLASS_SIZE_1    = 3'd1,
    CFG_CLASS_SIZE_2    = 3'd2,
    CFG_CLASS_SIZE_3    = 3'd3,
    CFG_CLASSES_IN_USE  = 3'd4,
    CFG_SLOTS_PER_BLOCK = 3'd5,
    CFG_BLOCK_LIMIT     = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_DEC  = 2'd1,
    FSM_EXE  = 2'd2
  } fsm_e;

  typedef struct packed {
    logic              ok;
    logic [ClassW-1:0] cls;
  } pick_t;

  // write port of the link memory
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [LinkW-1:0] data;
  } link_wr_t;

  // read port of the link memory
  typedef struct packed {
    logic             re;
    logic [AddrW-1:0] addr;
  } link_rd_t;

  // lowest searched class whose size covers the request
  function automatic pick_t pick_class(logic [SizeW-1:0]                 size,
                                       logic [CfgClasses-1:0][SizeW-1:0] sizes,
                                       logic [InUseW-1:0]                in_use);
    pick_t r;
    r = '0;
    for (int i = CfgClasses - 1; i >= 0; i--) begin
      if (i < NumClasses && InUseW'(i) < in_use && size <= sizes[i]) begin
        r.ok  = 1'b1;
        r.cls = ClassW'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/scsa_if.sv =====
// Request and response channel interfaces of the slab allocator.
interface scsa_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  command;
  logic [scsa_pkg::SizeW-1:0]  req_size;
  logic [scsa_pkg::SizeW-1:0]  grow_size;
  logic [scsa_pkg::SlotW-1:0]  slot_in;
  logic                        slot_in_null;

  modport source (output valid, command, req_size, grow_size, slot_in, slot_in_null,
                  input ready);
  modport sink   (input valid, command, req_size, grow_size, slot_in, slot_in_null,
                  output ready);
endinterface

interface scsa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [scsa_pkg::SlotW-1:0]  slot_out;
  logic [scsa_pkg::ClassW-1:0] class_out;
  logic [2:0]                  status;

  modport source (output valid, slot_out, class_out, status, input ready);
  modport sink   (input valid, slot_out, class_out, status, output ready);
endinterface

// ===== hdl/size_class_slab_allocator.sv =====
// Top level of the size-class slab allocator.
//
// Segregated-fit slab allocator. A request (allocate, free or resize) picks
// the lowest size class whose configured size covers req_size, searching
// classes_in_use classes. Each class keeps a LIFO free list whose links live
// in an on-chip memory of 4096 x 11 bits, indexed by {class, slot}; heads,
// list-nonempty flags and bump counters sit in flops. Allocation pops the
// list, otherwise takes the next bump slot, up to a capacity of 1024 slots or
// slots_per_block * block_limit when block_limit is nonzero and that is less.
// Every request transfer yields exactly one transfer on the response channel.
// Sequence: a request is taken; the next cycle (decode) reads the link memory
// at the head of the class that may be popped; the execute state then updates
// head, flags, counter and link memory and loads the response register. A new
// request can be taken on the same edge that loads the response, but none is
// taken during the decode, as the link memory is read before it is updated.
// While the response register is full and not taken, the update waits. The
// link memory is never cleared: a pop reads only entries written by the
// matching push, so no clearing pass follows reset. Configuration writes are
// taken at any edge with cfg_we_i high; the user must make them only while
// idle, as the block itself does not enforce this.
`include "size_class_slab_allocator_assert.svh"

module size_class_slab_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [scsa_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [scsa_pkg::CfgDataW-1:0]  cfg_data_i,
  scsa_req_if.sink                       req_i,
  scsa_rsp_if.source                     rsp_o
);

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [scsa_pkg::CfgClasses-1:0][scsa_pkg::SizeW-1:0] csize_q;
  logic [scsa_pkg::InUseW-1:0]  in_use_q;
  logic [scsa_pkg::CountW-1:0]  spb_q;
  logic [scsa_pkg::CountW-1:0]  blim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csize_q[0] <= scsa_pkg::SizeW'(4);
      csize_q[1] <= scsa_pkg::SizeW'(8);
      csize_q[2] <= scsa_pkg::SizeW'(16);
      csize_q[3] <= scsa_pkg::SizeW'(32);
      in_use_q   <= scsa_pkg::InUseW'(4);
      spb_q      <= scsa_pkg::CountW'(100);
      blim_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (scsa_pkg::cfg_idx_e'(cfg_idx_i))
        scsa_pkg::CFG_CLASS_SIZE_0:    csize_q[0] <= cfg_data_i;
        scsa_pkg::CFG_CLASS_SIZE_1:    csize_q[1] <= cfg_data_i;
        scsa_pkg::CFG_CLASS_SIZE_2:    csize_q[2] <= cfg_data_i;
        scsa_pkg::CFG_CLASS_SIZE_3:    csize_q[3] <= cfg_data_i;
        scsa_pkg::CFG_CLASSES_IN_USE:  in_use_q   <= cfg_data_i[scsa_pkg::InUseW-1:0];
        scsa_pkg::CFG_SLOTS_PER_BLOCK: spb_q      <= cfg_data_i[scsa_pkg::CountW-1:0];
        scsa_pkg::CFG_BLOCK_LIMIT:     blim_q     <= cfg_data_i[scsa_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // Capacity shared by all classes, registered after the multiply. It is first
  // used in the execute state, after the decode, so a write just before a request is seen.
  logic [scsa_pkg::ProdW-1:0]  prod;
  logic [scsa_pkg::CountW-1:0] cap_d, cap_q;

  always_comb begin
    prod  = spb_q * blim_q;
    cap_d = scsa_pkg::CountW'(scsa_pkg::SlotsPerClass);
    if (blim_q != '0 && prod < scsa_pkg::ProdW'(scsa_pkg::SlotsPerClass)) begin
      cap_d = prod[scsa_pkg::CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= scsa_pkg::CountW'(scsa_pkg::SlotsPerClass);
    end else begin
      cap_q <= cap_d;
    end
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  scsa_pkg::fsm_e state_q, state_d;
  logic           commit;
  logic           rsp_valid_q;
  logic           req_xfer;

  assign commit   = (state_q == scsa_pkg::FSM_EXE) && (!rsp_valid_q || rsp_o.ready);
  assign req_xfer = req_i.valid && req_i.ready;

  always_comb begin
    state_d     = state_q;
    req_i.ready = 1'b0;
    unique case (state_q)
      scsa_pkg::FSM_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          state_d = scsa_pkg::FSM_DEC;
        end
      end
      scsa_pkg::FSM_DEC: begin
        state_d = scsa_pkg::FSM_EXE;
      end
      scsa_pkg::FSM_EXE: begin
        // next request overlaps the commit of this one
        req_i.ready = commit;
        if (commit) begin
          state_d = req_i.valid ? scsa_pkg::FSM_DEC : scsa_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_d = scsa_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scsa_pkg::FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // request capture
  scsa_pkg::cmd_e              cmd_q;
  logic [scsa_pkg::SizeW-1:0]  size_q;
  logic [scsa_pkg::SizeW-1:0]  grow_q;
  logic [scsa_pkg::SlotW-1:0]  slot_q;
  logic                        null_q;

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      cmd_q  <= scsa_pkg::cmd_e'(req_i.command);
      size_q <= req_i.req_size;
      grow_q <= req_i.grow_size;
      slot_q <= req_i.slot_in;
      null_q <= req_i.slot_in_null;
    end
  end

  // ---------------------------------------------------------------------
  // per-class list state
  // ---------------------------------------------------------------------
  logic [scsa_pkg::NumClasses-1:0][scsa_pkg::CountW-1:0] bump_q;
  logic [scsa_pkg::NumClasses-1:0][scsa_pkg::SlotW-1:0]  head_q;
  logic [scsa_pkg::NumClasses-1:0]                       nonempty_q;

  // ---------------------------------------------------------------------
  // decode cycle: class search and link read at the head to be popped
  // ---------------------------------------------------------------------
  scsa_pkg::pick_t             c_d, nc_d, c_q, nc_q;
  logic [scsa_pkg::ClassW-1:0] tk_d, tk_q;
  logic                        shrink_q;
  scsa_pkg::link_rd_t          link_rd;
  scsa_pkg::link_wr_t          link_wr;
  logic [scsa_pkg::LinkW-1:0]  link_q;

  always_comb begin
    c_d          = scsa_pkg::pick_class(size_q, csize_q, in_use_q);
    nc_d         = scsa_pkg::pick_class(grow_q, csize_q, in_use_q);
    // allocate pops the request's class, resize the new class
    tk_d         = (cmd_q == scsa_pkg::CMD_ALLOC) ? c_d.cls : nc_d.cls;
    link_rd.re   = (state_q == scsa_pkg::FSM_DEC);
    link_rd.addr = {tk_d, head_q[tk_d]};
  end

  always_ff @(posedge clk_i) begin
    if (state_q == scsa_pkg::FSM_DEC) begin
      c_q      <= c_d;
      nc_q     <= nc_d;
      tk_q     <= tk_d;
      shrink_q <= (grow_q <= size_q);
    end
  end

  // The update writes on the commit edge and the next read is registered at the
  // end of the decode state that follows, so read and write of one entry never overlap.
  scsa_link_ram u_link_ram (
    .clk_i   (clk_i),
    .wr_i    (link_wr),
    .rd_i    (link_rd),
    .rdata_o (link_q)
  );

  // ---------------------------------------------------------------------
  // execute cycle
  // ---------------------------------------------------------------------
  logic                        pop;
  logic                        take_ok;
  logic [scsa_pkg::SlotW-1:0]  take_slot;
  logic                        do_take;
  logic                        do_push;
  logic [scsa_pkg::SlotW-1:0]  rsp_slot_d;
  logic [scsa_pkg::ClassW-1:0] rsp_cls_d;
  scsa_pkg::status_e           rsp_st_d;

  always_comb begin
    pop        = nonempty_q[tk_q];
    take_ok    = pop || (bump_q[tk_q] < cap_q);
    take_slot  = pop ? head_q[tk_q] : bump_q[tk_q][scsa_pkg::SlotW-1:0];
    do_take    = 1'b0;
    do_push    = 1'b0;
    rsp_slot_d = '0;
    rsp_cls_d  = '0;
    rsp_st_d   = scsa_pkg::ST_NOOP;
    case (cmd_q)
      scsa_pkg::CMD_ALLOC: begin
        if (!c_q.ok) begin
          rsp_st_d = scsa_pkg::ST_OVERSIZE;
        end else begin
          rsp_cls_d = c_q.cls;
          if (take_ok) begin
            do_take    = 1'b1;
            rsp_slot_d = take_slot;
            rsp_st_d   = scsa_pkg::ST_GRANTED;
          end else begin
            rsp_st_d = scsa_pkg::ST_EXHAUSTED;
          end
        end
      end
      scsa_pkg::CMD_FREE: begin
        if (!null_q) begin
          rsp_slot_d = slot_q;
          if (!c_q.ok) begin
            rsp_st_d = scsa_pkg::ST_OVERSIZE;
          end else begin
            rsp_cls_d = c_q.cls;
            do_push   = 1'b1;
            rsp_st_d  = scsa_pkg::ST_FREED;
          end
        end
      end
      scsa_pkg::CMD_RESIZE: begin
        if (!null_q) begin
          rsp_slot_d = slot_q;
          if (!c_q.ok) begin
            rsp_st_d = scsa_pkg::ST_OVERSIZE;
          end else begin
            rsp_cls_d = c_q.cls;
            if (shrink_q || (nc_q.ok && nc_q.cls == c_q.cls)) begin
              rsp_st_d = scsa_pkg::ST_FREED;
            end else if (!nc_q.ok) begin
              // old slot kept for a software copy
              rsp_st_d = scsa_pkg::ST_OVERSIZE;
            end else if (take_ok) begin
              // classes differ, so pop and push touch separate lists
              do_take    = 1'b1;
              do_push    = 1'b1;
              rsp_slot_d = take_slot;
              rsp_cls_d  = nc_q.cls;
              rsp_st_d   = scsa_pkg::ST_GRANTED;
            end else begin
              rsp_st_d = scsa_pkg::ST_EXHAUSTED;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // push: link the freed slot in front of the current head
  always_comb begin
    link_wr.we   = commit && do_push;
    link_wr.addr = {c_q.cls, slot_q};
    link_wr.data = nonempty_q[c_q.cls] ? {1'b1, head_q[c_q.cls]} : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bump_q     <= '0;
      head_q     <= '0;
      nonempty_q <= '0;
    end else if (commit) begin
      if (do_take) begin
        if (pop) begin
          if (link_q[scsa_pkg::LinkW-1]) begin
            head_q[tk_q] <= link_q[scsa_pkg::SlotW-1:0];
          end else begin
            nonempty_q[tk_q] <= 1'b0;
          end
        end else begin
          bump_q[tk_q] <= bump_q[tk_q] + scsa_pkg::CountW'(1);
        end
      end
      if (do_push) begin
        head_q[c_q.cls]     <= slot_q;
        nonempty_q[c_q.cls] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // response register
  // ---------------------------------------------------------------------
  logic [scsa_pkg::SlotW-1:0]  rsp_slot_q;
  logic [scsa_pkg::ClassW-1:0] rsp_cls_q;
  scsa_pkg::status_e           rsp_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (commit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      rsp_slot_q <= rsp_slot_d;
      rsp_cls_q  <= rsp_cls_d;
      rsp_st_q   <= rsp_st_d;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.slot_out  = rsp_slot_q;
  assign rsp_o.class_out = rsp_cls_q;
  assign rsp_o.status    = rsp_st_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  `SCSA_ASSERT_NEXT(a_xfer_to_dec, req_xfer, state_q == scsa_pkg::FSM_DEC, "request not decoded")
  `SCSA_ASSERT_IMPL(a_wr_on_commit, link_wr.we, state_q == scsa_pkg::FSM_EXE && commit, "stray link write")
  `SCSA_ASSERT_IMPL(a_rsp_from_exe, $rose(rsp_valid_q), $past(state_q) == scsa_pkg::FSM_EXE, "response without update")
  `SCSA_ASSERT_NEXT(a_push_nonempty, link_wr.we, nonempty_q != '0, "push left all lists empty")

endmodule

// ===== hdl/scsa_link_ram.sv =====
// Free-list link memory: one entry per class and slot, registered read.
module scsa_link_ram (
  input  logic                            clk_i,
  input  scsa_pkg::link_wr_t              wr_i,
  input  scsa_pkg::link_rd_t              rd_i,
  output logic [scsa_pkg::LinkW-1:0]      rdata_o
);

  logic [scsa_pkg::LinkW-1:0] mem [scsa_pkg::RamDepth];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.re) begin
      rdata_o <= mem[rd_i.addr];
    end
  end

endmodule
